// File: rtl/eeprom_row_write_buffer_assert.svh
// ----------------------------------------------------------------------------
// eeprom row write buffer assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef EEPROM_ROW_WRITE_BUFFER_ASSERT_SVH
`define EEPROM_ROW_WRITE_BUFFER_ASSERT_SVH

// same-cycle implication
`define ERWB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ERWB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/erwb_pkg.sv
// ----------------------------------------------------------------------------
// erwb_pkg
// shared constants, types and codes of the eeprom row write buffer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package erwb_pkg;

	localparam int ADDR_W         = 10;
	localparam int BYTE_W         = 8;
	localparam int DEF_ROW_BYTES  = 4;
	localparam int DEF_STORE_ROWS = 256;

	localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} seq_state_t;

	typedef struct packed {
		logic ready;
		logic accept;
		logic finish;
		logic clear_wr;
	} seq_ctrl_t;

endpackage

// File: rtl/erwb_ram.sv
// ----------------------------------------------------------------------------
// erwb_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module erwb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/erwb_seq.sv
// ----------------------------------------------------------------------------
// erwb_seq
// item sequencer and post-reset clearing pass over the row store
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module erwb_seq #(
	parameter int STORE_ROWS = erwb_pkg::DEF_STORE_ROWS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          out_free,
	output erwb_pkg::seq_ctrl_t           ctrl,
	output logic [$clog2(STORE_ROWS)-1:0] clr_addr
);

	localparam int ROW_W = $clog2(STORE_ROWS);
	localparam logic [ROW_W-1:0] CLR_END = ROW_W'(STORE_ROWS - 1);

	erwb_pkg::seq_state_t state_q, state_d;
	logic [ROW_W-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= erwb_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == erwb_pkg::ST_CLEAR) begin
				clr_q <= clr_q + ROW_W'(1);
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		ctrl          = '0;
		case (state_q)
			erwb_pkg::ST_CLEAR: begin
				ctrl.clear_wr = 1'b1;
				if (clr_q == CLR_END) begin
					state_d = erwb_pkg::ST_IDLE;
				end
			end
			erwb_pkg::ST_IDLE: begin
				ctrl.ready  = 1'b1;
				ctrl.accept = in_valid;
				if (in_valid) begin
					state_d = erwb_pkg::ST_EXEC;
				end
			end
			erwb_pkg::ST_EXEC: begin
				ctrl.finish = out_free;
				if (out_free) begin
					state_d = erwb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = erwb_pkg::ST_CLEAR;
			end
		endcase
	end

	assign clr_addr = clr_q;

endmodule

// File: rtl/eeprom_row_write_buffer.sv
// ----------------------------------------------------------------------------
// eeprom_row_write_buffer
// one-row write-back buffer in front of a row-programmed store
// ----------------------------------------------------------------------------
// An item is accepted in ST_IDLE, which issues the store read (and any
// write-back of a dirty row being evicted); ST_EXEC then uses the registered
// read data to finish the item and, on a flush, program the row. ST_EXEC
// finishes only while the output register is free, so an item waits while the
// previous result sits unaccepted there, and no new item is accepted before
// the current one finishes. After reset a clearing pass erases every row of
// the store, during which in_ready stays low. Reads return the store contents,
// so an edit still held in the buffer is not seen by a read.
`timescale 1ns / 1ps

module eeprom_row_write_buffer #(
	parameter int ROW_BYTES  = erwb_pkg::DEF_ROW_BYTES,
	parameter int STORE_ROWS = erwb_pkg::DEF_STORE_ROWS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        opcode,
	input  logic [erwb_pkg::ADDR_W-1:0] byte_address,
	input  logic [erwb_pkg::BYTE_W-1:0] write_byte,
	input  logic                        flush_now,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [erwb_pkg::BYTE_W-1:0] read_byte,
	output logic                        byte_changed,
	output logic                        row_programmed
);

	`include "eeprom_row_write_buffer_assert.svh"

	localparam int ROW_W  = $clog2(STORE_ROWS);
	localparam int POS_W  = $clog2(ROW_BYTES);
	localparam int WIDE_W = ((erwb_pkg::ADDR_W > ROW_W) ? erwb_pkg::ADDR_W : ROW_W) + 1;
	localparam int WORD_W = ROW_BYTES * erwb_pkg::BYTE_W;

	typedef logic [ROW_BYTES-1:0][erwb_pkg::BYTE_W-1:0] row_t;

	erwb_pkg::seq_ctrl_t ctrl;
	logic [ROW_W-1:0]    clr_addr;
	logic                out_free;

	logic [WIDE_W-1:0] row_wide;
	logic [WIDE_W-1:0] pos_wide;
	logic [ROW_W-1:0]  row_idx;
	logic [POS_W-1:0]  pos_idx;
	logic              hit;
	logic              evict;

	logic              op_q, flush_q, hit_q, prog_q;
	logic [ROW_W-1:0]  row_q;
	logic [POS_W-1:0]  pos_q;
	logic [erwb_pkg::BYTE_W-1:0] val_q;

	logic              row_open_q, row_dirty_q;
	logic [ROW_W-1:0]  open_row_q;
	row_t              buf_q;

	logic              out_valid_q, changed_q, programmed_q;
	logic [erwb_pkg::BYTE_W-1:0] read_byte_q;

	logic [WORD_W-1:0] rdata;
	row_t              rd_row, base_row, new_row;
	logic              chg, dirty_n, is_write, flush_wr;

	logic              ram_we;
	logic [ROW_W-1:0]  ram_waddr;
	logic [WORD_W-1:0] ram_wdata;

	assign row_wide = (WIDE_W'(byte_address) / WIDE_W'(ROW_BYTES)) % WIDE_W'(STORE_ROWS);
	assign pos_wide = WIDE_W'(byte_address) % WIDE_W'(ROW_BYTES);
	assign row_idx  = row_wide[ROW_W-1:0];
	assign pos_idx  = pos_wide[POS_W-1:0];
	assign hit      = row_open_q && (open_row_q == row_idx);
	assign evict    = ctrl.accept && (opcode == erwb_pkg::OP_WRITE) && row_open_q
		&& !hit && row_dirty_q;

	assign out_free = !out_valid_q || out_ready;

	erwb_seq #(
		.STORE_ROWS(STORE_ROWS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.out_free(out_free),
		.ctrl    (ctrl),
		.clr_addr(clr_addr)
	);

	// merge of the addressed byte into the open or freshly loaded row
	assign rd_row   = rdata;
	assign base_row = hit_q ? buf_q : rd_row;
	assign is_write = (op_q == erwb_pkg::OP_WRITE);
	assign chg      = (base_row[pos_q] != val_q);
	assign dirty_n  = (hit_q && row_dirty_q) || chg;
	assign flush_wr = ctrl.finish && is_write && flush_q && dirty_n;

	always_comb begin
		new_row        = base_row;
		new_row[pos_q] = val_q;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = row_q;
		ram_wdata = new_row;
		if (ctrl.clear_wr) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr;
			ram_wdata = {ROW_BYTES{erwb_pkg::ERASED_BYTE}};
		end else if (evict) begin
			ram_we    = 1'b1;
			ram_waddr = open_row_q;
			ram_wdata = buf_q;
		end else if (flush_wr) begin
			ram_we = 1'b1;
		end
	end

	erwb_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STORE_ROWS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ctrl.accept),
		.raddr(row_idx),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			op_q    <= opcode;
			flush_q <= flush_now;
			row_q   <= row_idx;
			pos_q   <= pos_idx;
			val_q   <= write_byte;
			hit_q   <= hit;
			prog_q  <= evict;
		end
		if (ctrl.finish && is_write) begin
			buf_q <= new_row;
		end
		if (ctrl.finish) begin
			read_byte_q  <= is_write ? '0 : rd_row[pos_q];
			changed_q    <= is_write && chg;
			programmed_q <= is_write && (prog_q || (flush_q && dirty_n));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_open_q  <= 1'b0;
			row_dirty_q <= 1'b0;
			open_row_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.finish && is_write) begin
				open_row_q  <= row_q;
				row_open_q  <= !flush_q;
				row_dirty_q <= flush_q ? 1'b0 : dirty_n;
			end
			if (ctrl.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready       = ctrl.ready;
	assign out_valid      = out_valid_q;
	assign read_byte      = read_byte_q;
	assign byte_changed   = changed_q;
	assign row_programmed = programmed_q;

	`ERWB_ASSERT_NOW(a_closed_is_clean, !row_open_q, !row_dirty_q, "closed row marked dirty")
	`ERWB_ASSERT_NOW(a_evict_other_row, evict, ram_waddr != row_idx, "evict hits loaded row")
	`ERWB_ASSERT_NEXT(a_flush_closes, ctrl.finish && is_write && flush_q, !row_open_q,
		"flush left row open")
	`ERWB_ASSERT_NEXT(a_finish_shows, ctrl.finish, out_valid, "finished item not presented")

endmodule
